// ----- hdl/tlcr_pkg.sv -----
// ----------------------------------------------------------------------------
// tlcr_pkg
// Types and constants shared by the text line cell renderer modules.
// ----------------------------------------------------------------------------
package tlcr_pkg;

   localparam int LCOL_W = 12;   // logical column width
   localparam int TABW_W = 6;    // tab width register width
   localparam int SCOL_W = 8;    // screen column / cell budget width
   localparam int SOFF_W = 10;   // scroll offset width
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DAT_W = 10;

   localparam logic [6:0] CHAR_TAB    = 7'h09;
   localparam logic [6:0] CHAR_SPACE  = 7'h20;
   localparam logic [6:0] CHAR_BANG   = 7'h21;
   localparam logic [6:0] CHAR_GT     = 7'h3E;
   localparam logic [6:0] CHAR_QMARK  = 7'h3F;
   localparam logic [6:0] CHAR_AT     = 7'h40;
   localparam logic [6:0] CHAR_CARET  = 7'h5E;
   localparam logic [6:0] CHAR_UNDER  = 7'h5F;
   localparam logic [6:0] CHAR_DEL    = 7'h7F;
   localparam logic [6:0] CHAR_FIRST_PRINT = 7'h20;

   localparam logic [TABW_W-1:0] TAB_MAX = 6'd32;

   localparam logic [CSR_IDX_W-1:0] CSR_TAB_WIDTH     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LINE_WIDTH    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SCROLL_OFFSET = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_VISIBLE_SPACE = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_INVERSE_VIDEO = 3'd4;

   typedef struct packed {
      logic [6:0] char_code;
      logic       first_of_line;
   } req_item_type;

   typedef struct packed {
      logic [7:0] cell_char;
      logic [7:0] cell_column;
      logic       truncated;
      logic       last_of_run;
   } rsp_item_type;

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_DIV  = 4'b0010,
      ST_EVAL = 4'b0100,
      ST_EMIT = 4'b1000
   } state_type;

endpackage

// ----- hdl/text_line_cell_renderer_top.sv -----
// ----------------------------------------------------------------------------
// text_line_cell_renderer_top
// Renders 7-bit text line characters into screen cells: tab expansion,
// caret notation for control characters, horizontal scroll and truncation.
// ----------------------------------------------------------------------------
//
//   channel  direction  handshake              payload
//   req      in         req_valid / req_ready  req_item  (char_code, first_of_line)
//   rsp      out        rsp_valid / rsp_ready  rsp_item  (cell_char, cell_column,
//                                                         truncated, last_of_run)
//   csr      in         csr_valid / csr_ready  csr_index, csr_wdata (always ready)
//
// A plain character goes from accept through evaluation to its cell in the
// output register; a control character takes two cells. A tab first runs
// the remainder unit (one column bit per cycle), then evaluation, then emits
// its cells while the output register can take them. A skipped character
// ends at evaluation (a tab after the remainder unit). Synchronous reset
// clears control state and loads the register reset values. A stalled rsp
// holds the cell in the output register and pauses emission; req is taken
// again as soon as the sequencer is back in idle.
// ----------------------------------------------------------------------------
module text_line_cell_renderer_top (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  tlcr_pkg::req_item_type            req_item,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output tlcr_pkg::rsp_item_type            rsp_item,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [tlcr_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [tlcr_pkg::CSR_DAT_W-1:0]    csr_wdata
);
   import tlcr_pkg::*;

   // configuration registers
   logic [TABW_W-1:0] tab_width_ff;
   logic [SCOL_W-1:0] line_width_ff;
   logic [SOFF_W-1:0] scroll_offset_ff;
   logic              visible_space_ff;
   logic              inverse_video_ff;

   // line state
   logic [LCOL_W-1:0] logical_column_ff, logical_column_in;
   logic [SCOL_W-1:0] cells_left_ff, cells_left_in;
   logic [SCOL_W-1:0] screen_column_ff, screen_column_in;
   logic              skipping_ff, skipping_in;
   logic              line_done_ff, line_done_in;

   // sequencer
   state_type         state_ff, state_in;
   logic [6:0]        char_ff, char_in;
   logic [TABW_W-1:0] run_len_ff, run_len_in;
   logic [TABW_W-1:0] cell_idx_ff, cell_idx_in;

   // output register
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_item_type      rsp_item_ff, rsp_item_in;

   logic              req_fire;
   logic              csr_fire;
   logic [TABW_W-1:0] tw_eff;
   logic              is_tab, is_ctrl;
   logic [TABW_W-1:0] step_len;
   logic [6:0]        glyph;
   logic              slot_free;
   logic              cell_load;
   logic              cell_trunc;
   logic              cell_last;
   logic              rem_start;
   logic              rem_done;
   logic [TABW_W-1:0] rem_val;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign csr_ready = 1'b1;
   assign csr_fire  = csr_valid;

   // clamp tab width: zero acts as one, anything above the maximum as maximum
   always_comb begin
      if (tab_width_ff == '0) begin
         tw_eff = TABW_W'(1);
      end else if (tab_width_ff > TAB_MAX) begin
         tw_eff = TAB_MAX;
      end else begin
         tw_eff = tab_width_ff;
      end
   end

   assign is_tab  = (char_ff == CHAR_TAB);
   assign is_ctrl = (char_ff < CHAR_FIRST_PRINT) || (char_ff == CHAR_DEL);

   // columns this character occupies
   always_comb begin
      if (is_tab) begin
         step_len = tw_eff - rem_val;
      end else if (is_ctrl) begin
         step_len = TABW_W'(2);
      end else begin
         step_len = TABW_W'(1);
      end
   end

   // glyph for the current cell of the run
   always_comb begin
      if (is_tab) begin
         glyph = (cell_idx_ff == '0 && visible_space_ff) ? CHAR_GT : CHAR_SPACE;
      end else if (is_ctrl) begin
         if (cell_idx_ff == '0) begin
            glyph = CHAR_CARET;
         end else if (char_ff == CHAR_DEL) begin
            glyph = CHAR_QMARK;
         end else begin
            glyph = char_ff + CHAR_AT;
         end
      end else begin
         glyph = (visible_space_ff && char_ff == CHAR_SPACE) ? CHAR_UNDER : char_ff;
      end
   end

   assign slot_free  = !rsp_valid_ff || rsp_ready;
   assign cell_load  = (state_ff == ST_EMIT) && slot_free;
   assign cell_trunc = (cells_left_ff <= SCOL_W'(1));
   assign cell_last  = cell_trunc || (cell_idx_ff == run_len_ff - TABW_W'(1));

   always_comb begin
      logical_column_in = logical_column_ff;
      cells_left_in     = cells_left_ff;
      screen_column_in  = screen_column_ff;
      skipping_in       = skipping_ff;
      line_done_in      = line_done_ff;
      state_in          = state_ff;
      char_in           = char_ff;
      run_len_in        = run_len_ff;
      cell_idx_in       = cell_idx_ff;
      rem_start         = 1'b0;
      rsp_valid_in      = rsp_valid_ff && !rsp_ready;
      rsp_item_in       = rsp_item_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               char_in = req_item.char_code;
               // restart the line before handling this character
               if (req_item.first_of_line) begin
                  logical_column_in = '0;
                  cells_left_in     = line_width_ff;
                  screen_column_in  = '0;
                  skipping_in       = 1'b1;
                  line_done_in      = 1'b0;
               end
               if (req_item.char_code == CHAR_TAB) begin
                  rem_start = 1'b1;
                  state_in  = ST_DIV;
               end else begin
                  state_in  = ST_EVAL;
               end
            end
         end
         ST_DIV: begin
            // hold until the remainder unit finishes
            if (rem_done) begin
               state_in = ST_EVAL;
            end
         end
         ST_EVAL: begin
            if (char_ff == '0 || line_done_ff) begin
               // drop the character
               state_in = ST_IDLE;
            end else if (skipping_ff &&
                         (logical_column_ff < {{(LCOL_W-SOFF_W){1'b0}}, scroll_offset_ff})) begin
               // still left of the scroll offset: advance only
               logical_column_in = logical_column_ff + LCOL_W'(step_len);
               state_in          = ST_IDLE;
            end else begin
               skipping_in       = 1'b0;
               logical_column_in = logical_column_ff + LCOL_W'(step_len);
               run_len_in        = step_len;
               cell_idx_in       = '0;
               state_in          = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (cell_load) begin
               rsp_valid_in            = 1'b1;
               rsp_item_in.cell_column = screen_column_ff;
               rsp_item_in.last_of_run = cell_last;
               if (cell_trunc) begin
                  // budget exhausted: mark and finish the line
                  rsp_item_in.cell_char = {inverse_video_ff, CHAR_BANG};
                  rsp_item_in.truncated = 1'b1;
                  cells_left_in         = '0;
                  line_done_in          = 1'b1;
               end else begin
                  rsp_item_in.cell_char = {inverse_video_ff, glyph};
                  rsp_item_in.truncated = 1'b0;
                  cells_left_in         = cells_left_ff - SCOL_W'(1);
                  screen_column_in      = screen_column_ff + SCOL_W'(1);
               end
               if (cell_last) begin
                  state_in = ST_IDLE;
               end else begin
                  cell_idx_in = cell_idx_ff + TABW_W'(1);
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   tlcr_rem_unit u_rem (
      .clock     (clock),
      .reset     (reset),
      .start     (rem_start),
      .dividend  (logical_column_in),
      .divisor   (tw_eff),
      .done      (rem_done),
      .remainder (rem_val)
   );

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         tab_width_ff     <= TABW_W'(8);
         line_width_ff    <= SCOL_W'(79);
         scroll_offset_ff <= '0;
         visible_space_ff <= 1'b0;
         inverse_video_ff <= 1'b0;
      end else if (csr_fire) begin
         unique case (csr_index)
            CSR_TAB_WIDTH:     tab_width_ff     <= csr_wdata[TABW_W-1:0];
            CSR_LINE_WIDTH:    line_width_ff    <= csr_wdata[SCOL_W-1:0];
            CSR_SCROLL_OFFSET: scroll_offset_ff <= csr_wdata[SOFF_W-1:0];
            CSR_VISIBLE_SPACE: visible_space_ff <= csr_wdata[0];
            CSR_INVERSE_VIDEO: inverse_video_ff <= csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff          <= ST_IDLE;
         logical_column_ff <= '0;
         cells_left_ff     <= SCOL_W'(79);
         screen_column_ff  <= '0;
         skipping_ff       <= 1'b0;
         line_done_ff      <= 1'b0;
         rsp_valid_ff      <= 1'b0;
      end else begin
         state_ff          <= state_in;
         logical_column_ff <= logical_column_in;
         cells_left_ff     <= cells_left_in;
         screen_column_ff  <= screen_column_in;
         skipping_ff       <= skipping_in;
         line_done_ff      <= line_done_in;
         rsp_valid_ff      <= rsp_valid_in;
      end
      char_ff     <= char_in;
      run_len_ff  <= run_len_in;
      cell_idx_ff <= cell_idx_in;
      rsp_item_ff <= rsp_item_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

`ifndef NO_ASSERTIONS
   // a finished line never has a run in progress
   a_emit_not_done: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT) |-> !line_done_ff)
      else $error("emitting cells on a finished line");

   // the overflow mark ends the run and the line
   a_trunc_ends: assert property (@(posedge clock) disable iff (reset)
      (cell_load && cell_trunc) |=> (rsp_item_ff.last_of_run && line_done_ff
                                     && state_ff == ST_IDLE))
      else $error("overflow mark did not close the line");

   // every normal cell consumes one unit of budget
   a_budget_step: assert property (@(posedge clock) disable iff (reset)
      (cell_load && !cell_trunc) |=> (cells_left_ff == $past(cells_left_ff) - SCOL_W'(1)))
      else $error("cell budget did not decrement");

   // the remainder is always below the tab width
   a_rem_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV && rem_done) |-> (rem_val < tw_eff))
      else $error("tab remainder out of range");
`endif

endmodule

// ----- hdl/tlcr_rem_unit.sv -----
// ----------------------------------------------------------------------------
// tlcr_rem_unit
// Restoring remainder unit: column modulo tab width, one bit per cycle.
// ----------------------------------------------------------------------------
module tlcr_rem_unit (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [tlcr_pkg::LCOL_W-1:0]  dividend,
   input  logic [tlcr_pkg::TABW_W-1:0]  divisor,
   output logic                         done,
   output logic [tlcr_pkg::TABW_W-1:0]  remainder
);
   import tlcr_pkg::*;

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [3:0]           step_ff, step_in;
   logic [LCOL_W-1:0]    num_ff, num_in;
   logic [TABW_W-1:0]    rem_ff, rem_in;
   logic [TABW_W:0]      trial;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      num_in  = num_ff;
      rem_in  = rem_ff;
      trial   = {rem_ff, num_ff[step_ff]};
      if (start) begin
         busy_in = 1'b1;
         step_in = 4'(LCOL_W - 1);
         num_in  = dividend;
         rem_in  = '0;
      end else if (busy_ff) begin
         // shift in one dividend bit, subtract when it fits
         if (trial >= {1'b0, divisor}) begin
            rem_in = TABW_W'(trial - {1'b0, divisor});
         end else begin
            rem_in = trial[TABW_W-1:0];
         end
         if (step_ff == 4'd0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            step_in = step_ff - 4'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      step_ff <= step_in;
      num_ff  <= num_in;
      rem_ff  <= rem_in;
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

endmodule
